// File: rtl/wkst_pkg.sv
// Shared types and constants for the weighted k-th smallest table unit.
package wkst_pkg;

   localparam int unsigned MAX_DISTINCT_DEF = 1024;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned POS_W   = 42;
   localparam int unsigned WORD_W  = VALUE_W + COUNT_W;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic       capture;
      logic       idx_clr;
      logic       idx_inc;
      logic       idx_load_end;
      logic       idx_dec;
      logic       rd_scan;
      logic       rd_shift;
      logic       wr_update;
      logic       wr_shift;
      logic       wr_insert;
      logic       cum_acc;
      logic       ptot_add;
      logic       ent_inc;
      logic       res_set;
      status_type res_status;
      logic       res_found;
      logic       rsp_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic mode;
      logic idx_lt_ent;
      logic key_lt;
      logic key_eq;
      logic full;
      logic pos_bad;
      logic hit;
      logic at_ins;
   } sts_type;

endpackage

// File: rtl/wkst_if.sv
// Valid/ready channel interfaces for requests and responses.
interface wkst_req_if;
   import wkst_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       mode;
   logic signed [VALUE_W-1:0]  item_value;
   logic        [COUNT_W-1:0]  item_count;
   logic        [POS_W-1:0]    position;
   modport source (output valid, mode, item_value, item_count, position, input ready);
   modport sink   (input valid, mode, item_value, item_count, position, output ready);
endinterface

interface wkst_rsp_if;
   import wkst_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  found_value;
   logic        [1:0]          status;
   modport source (output valid, found_value, status, input ready);
   modport sink   (input valid, found_value, status, output ready);
endinterface

// File: rtl/wkst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wkst_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/wkst_datapath.sv
// Datapath: entry RAM, scan index, running sums and result registers.
module wkst_datapath #(
   parameter int unsigned MAX_DISTINCT = wkst_pkg::MAX_DISTINCT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  wkst_pkg::cmd_type                  cmd,
   output wkst_pkg::sts_type                  sts,
   input  logic                               req_mode,
   input  logic signed [wkst_pkg::VALUE_W-1:0] req_item_value,
   input  logic [wkst_pkg::COUNT_W-1:0]       req_item_count,
   input  logic [wkst_pkg::POS_W-1:0]         req_position,
   output logic signed [wkst_pkg::VALUE_W-1:0] rsp_found_value,
   output wkst_pkg::status_type               rsp_status
);
   import wkst_pkg::*;

   localparam int unsigned AW = $clog2(MAX_DISTINCT);
   localparam int unsigned EW = $clog2(MAX_DISTINCT + 1);
   localparam int unsigned CW = POS_W + 1;

   logic                      mode_ff;
   logic signed [VALUE_W-1:0] val_ff;
   logic [COUNT_W-1:0]        cnt_ff;
   logic [POS_W-1:0]          pos_ff;
   logic [EW-1:0]             idx_ff, idx_in;
   logic [EW-1:0]             ins_ff;
   logic [EW-1:0]             ent_ff;
   logic [POS_W-1:0]          ptot_ff;
   logic [CW-1:0]             cum_ff, cum_in;
   logic signed [VALUE_W-1:0] res_value_ff;
   status_type                res_status_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   status_type                rsp_status_ff;

   logic                      wr_en, rd_en;
   logic [AW-1:0]             wr_addr, rd_addr;
   logic [WORD_W-1:0]         wr_data, rd_data;
   logic signed [VALUE_W-1:0] ent_value;
   logic [COUNT_W-1:0]        ent_count;
   logic [COUNT_W:0]          cnt_sum;
   logic [COUNT_W-1:0]        cnt_sat;
   logic [CW-1:0]             ptot_sum;
   logic [EW-1:0]             idx_m1;

   assign ent_value = $signed(rd_data[WORD_W-1:COUNT_W]);
   assign ent_count = rd_data[COUNT_W-1:0];
   assign cnt_sum   = {1'b0, ent_count} + {1'b0, cnt_ff};
   assign cnt_sat   = cnt_sum[COUNT_W] ? '1 : cnt_sum[COUNT_W-1:0];
   assign ptot_sum  = {1'b0, ptot_ff} + CW'(cnt_ff);
   assign cum_in    = cum_ff + CW'(ent_count);
   assign idx_m1    = idx_ff - EW'(1);

   assign wr_en   = cmd.wr_update | cmd.wr_shift | cmd.wr_insert;
   assign wr_addr = idx_ff[AW-1:0];
   assign rd_en   = cmd.rd_scan | cmd.rd_shift;
   assign rd_addr = cmd.rd_shift ? idx_m1[AW-1:0] : idx_ff[AW-1:0];

   always_comb begin
      if (cmd.wr_update) begin
         wr_data = {val_ff, cnt_sat};
      end else if (cmd.wr_shift) begin
         wr_data = rd_data;
      end else begin
         wr_data = {val_ff, cnt_ff};
      end
   end

   wkst_ram #(.WIDTH(WORD_W), .DEPTH(MAX_DISTINCT)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + EW'(1);
      end else if (cmd.idx_load_end) begin
         idx_in = ent_ff;
      end else if (cmd.idx_dec) begin
         idx_in = idx_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff  <= '0;
         ptot_ff <= '0;
      end else begin
         if (cmd.ent_inc) begin
            ent_ff <= ent_ff + EW'(1);
         end
         if (cmd.ptot_add) begin
            ptot_ff <= ptot_sum[POS_W] ? '1 : ptot_sum[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.capture) begin
         mode_ff <= req_mode;
         val_ff  <= req_item_value;
         cnt_ff  <= req_item_count;
         pos_ff  <= req_position;
         cum_ff  <= '0;
      end else if (cmd.cum_acc) begin
         cum_ff <= cum_in;
      end
      if (cmd.idx_load_end) begin
         ins_ff <= idx_ff;
      end
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_status;
         res_value_ff  <= cmd.res_found ? ent_value : '0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
      end
   end

   assign sts.mode       = mode_ff;
   assign sts.idx_lt_ent = idx_ff < ent_ff;
   assign sts.key_lt     = ent_value < val_ff;
   assign sts.key_eq     = ent_value == val_ff;
   assign sts.full       = ent_ff == EW'(MAX_DISTINCT);
   assign sts.pos_bad    = (pos_ff == '0) || (pos_ff > ptot_ff);
   assign sts.hit        = {1'b0, pos_ff} <= cum_in;
   assign sts.at_ins     = idx_ff == ins_ff;

   assign rsp_found_value = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
endmodule

// File: rtl/wkst_ctrl.sv
// Controller: sequences scan, shift and response for one item at a time.
module wkst_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  wkst_pkg::sts_type sts,
   output wkst_pkg::cmd_type cmd
);
   import wkst_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_START, S_SCAN_RD, S_SCAN_CHK, S_SHIFT_RD, S_SHIFT_WR, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      cmd.res_status = ST_OK;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               cmd.idx_clr = 1'b1;
               state_in    = S_START;
            end
         end
         S_START: begin
            if (sts.mode && sts.pos_bad) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_RANGE;
               state_in       = S_DONE;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (sts.idx_lt_ent) begin
               cmd.rd_scan = 1'b1;
               state_in    = S_SCAN_CHK;
            end else if (sts.mode) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_RANGE;
               state_in       = S_DONE;
            end else if (sts.full) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_FULL;
               state_in       = S_DONE;
            end else begin
               cmd.idx_load_end = 1'b1;
               state_in         = S_SHIFT_RD;
            end
         end
         S_SCAN_CHK: begin
            if (sts.mode) begin
               cmd.cum_acc = 1'b1;
               if (sts.hit) begin
                  cmd.res_set   = 1'b1;
                  cmd.res_found = 1'b1;
                  state_in      = S_DONE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_SCAN_RD;
               end
            end else if (sts.key_lt) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end else if (sts.key_eq) begin
               cmd.wr_update = 1'b1;
               cmd.ptot_add  = 1'b1;
               cmd.res_set   = 1'b1;
               state_in      = S_DONE;
            end else if (sts.full) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_FULL;
               state_in       = S_DONE;
            end else begin
               cmd.idx_load_end = 1'b1;
               state_in         = S_SHIFT_RD;
            end
         end
         S_SHIFT_RD: begin
            if (sts.at_ins) begin
               cmd.wr_insert = 1'b1;
               cmd.ent_inc   = 1'b1;
               cmd.ptot_add  = 1'b1;
               cmd.res_set   = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.rd_shift = 1'b1;
               state_in     = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.idx_dec  = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
endmodule

// File: rtl/weighted_kth_smallest_table_unit.sv
// Top level of the weighted k-th smallest table unit.
//
//  channel | dir | payload                                     | transfer
//  req_ch  | in  | mode, item_value, item_count, position      | valid & ready
//  rsp_ch  | out | found_value, status                         | valid & ready
//
// One item at a time; a request is taken only while the controller is idle.
// Add: each entry below the value is read and checked, then on insert each
// entry above the slot is read and written one place up before the write.
// Query: entries are read in turn and their counts summed until the rank.
// The single read port of the entry RAM (registered read) sets the pace.
// Synchronous reset empties the table at once (entry count and total cleared).
// A finished result waits in the output register; the next request is taken
// meanwhile and only its completion stalls on a held response.
module weighted_kth_smallest_table_unit #(
   parameter int unsigned MAX_DISTINCT = wkst_pkg::MAX_DISTINCT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   wkst_req_if.sink   req_ch,
   wkst_rsp_if.source rsp_ch
);
   import wkst_pkg::*;

   cmd_type    cmd;
   sts_type    sts;
   status_type rsp_status;

   wkst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // entries stored as {value, count} words, ascending by signed value
   wkst_datapath #(.MAX_DISTINCT(MAX_DISTINCT)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_mode        (req_ch.mode),
      .req_item_value  (req_ch.item_value),
      .req_item_count  (req_ch.item_count),
      .req_position    (req_ch.position),
      .rsp_found_value (rsp_ch.found_value),
      .rsp_status      (rsp_status)
   );

   assign rsp_ch.status = rsp_status;
endmodule

// File: rtl/wkst_checker.sv
// Port-level checker for the table unit, bound to the top level.
module wkst_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] found_value,
   input logic [1:0]  status
);
   import wkst_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (status == ST_OK || status == ST_FULL || status == ST_RANGE))
      else $error("undefined status code");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != ST_OK |-> found_value == '0)
      else $error("value not zero on error");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");
endmodule

bind weighted_kth_smallest_table_unit wkst_checker u_wkst_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .found_value (rsp_ch.found_value),
   .status      (rsp_ch.status)
);

// File: test/weighted_kth_smallest_table_unit_tb.sv
// Self-checking testbench for the weighted k-th smallest table unit.
`timescale 1ns / 1ps

module weighted_kth_smallest_table_unit_tb;
   import wkst_pkg::*;

   localparam int unsigned TABLE_DEPTH = MAX_DISTINCT_DEF;
   localparam logic [POS_W-1:0] RANK_MAX = {POS_W{1'b1}};
   localparam logic MODE_ADD   = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct {
      logic              mode;
      logic [31:0]       item_value;
      logic [31:0]       item_count;
      logic [POS_W-1:0]  position;
      logic              typed;      // expectation typed into the table row
      logic [31:0]       want_value;
      status_type        want_status;
   } stim_row_type;

   typedef struct {
      logic [31:0] found_value;
      status_type  status;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wkst_req_if req_ch ();
   wkst_rsp_if rsp_ch ();

   weighted_kth_smallest_table_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: sorted distinct values with their repeat counts.
   logic [31:0]      shadow_values [TABLE_DEPTH];
   logic [31:0]      shadow_counts [TABLE_DEPTH];
   int unsigned      shadow_entries;
   logic [POS_W-1:0] shadow_total;

   answer_type answers_due [$];
   int unsigned fault_count;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   bit          recv_hold;
   bit          stimulus_done;

   // Fold one add into the shadow table, returning the status it gives.
   function automatic status_type shadow_add(logic [31:0] val, logic [31:0] cnt);
      int unsigned slot;
      logic [32:0] sum;
      logic [POS_W:0] grand;
      slot = 0;
      while (slot < shadow_entries &&
             $signed(shadow_values[slot]) < $signed(val))
         slot++;
      if (slot < shadow_entries && shadow_values[slot] == val) begin
         sum = {1'b0, shadow_counts[slot]} + cnt;
         shadow_counts[slot] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end else begin
         if (shadow_entries >= TABLE_DEPTH)
            return ST_FULL;
         for (int unsigned k = shadow_entries; k > slot; k--) begin
            shadow_values[k] = shadow_values[k-1];
            shadow_counts[k] = shadow_counts[k-1];
         end
         shadow_values[slot] = val;
         shadow_counts[slot] = cnt;
         shadow_entries++;
      end
      grand = {1'b0, shadow_total} + cnt;
      shadow_total = grand[POS_W] ? RANK_MAX : grand[POS_W-1:0];
      return ST_OK;
   endfunction

   // Predict the answer to one item and advance the shadow state.
   function automatic answer_type predict_answer(stim_row_type it);
      answer_type a;
      logic [POS_W+10:0] cum;
      a.found_value = '0;
      a.status = ST_OK;
      if (it.mode == MODE_ADD) begin
         a.status = shadow_add(it.item_value, it.item_count);
      end else begin
         a.status = ST_RANGE;
         cum = '0;
         if (it.position != 0 && it.position <= shadow_total) begin
            for (int unsigned k = 0; k < shadow_entries; k++) begin
               cum += shadow_counts[k];
               if (it.position <= cum) begin
                  a.found_value = shadow_values[k];
                  a.status = ST_OK;
                  break;
               end
            end
         end
      end
      return a;
   endfunction

   function automatic stim_row_type add_row(logic [31:0] v, logic [31:0] c);
      stim_row_type r;
      r = '{MODE_ADD, v, c, '0, 1'b0, '0, ST_OK};
      return r;
   endfunction

   function automatic stim_row_type query_row(logic [POS_W-1:0] p);
      stim_row_type r;
      r = '{MODE_QUERY, '0, '0, p, 1'b0, '0, ST_OK};
      return r;
   endfunction

   function automatic stim_row_type typed_row(stim_row_type r, logic [31:0] v,
                                              status_type s);
      r.typed = 1'b1;
      r.want_value = v;
      r.want_status = s;
      return r;
   endfunction

   // Offer one item at the falling edge and hold it until the transfer.
   task automatic offer_item(stim_row_type it);
      answer_type a;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.mode       <= it.mode;
      req_ch.item_value <= it.item_value;
      req_ch.item_count <= it.item_count;
      req_ch.position   <= it.position;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      a = predict_answer(it);
      if (it.typed && (a.found_value !== it.want_value || a.status !== it.want_status)) begin
         $display("%0t predictor disagrees with table row: exp %h/%0d got %h/%0d",
                  $time, it.want_value, it.want_status, a.found_value, a.status);
         fault_count++;
      end
      answers_due.insert(answers_due.size(), a);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(15) - 8;
         default: return $urandom_range(199) - 100;
      endcase
   endfunction

   function automatic logic [31:0] pick_count();
      case ($urandom_range(9))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF - $urandom_range(3);
         2: return $urandom();
         default: return $urandom_range(20);
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_rank();
      logic [POS_W-1:0] r;
      case ($urandom_range(9))
         0: return '0;
         1: return shadow_total + POS_W'(1);
         2: return POS_W'({$urandom(), $urandom()});
         3: return shadow_total;
         default: begin
            r = POS_W'({$urandom(), $urandom()});
            return (shadow_total == 0) ? POS_W'(1) : (r % shadow_total) + POS_W'(1);
         end
      endcase
   endfunction

   // Response side: random back-pressure, plus one long hold-off.
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         rsp_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each response transfer with the oldest expected answer.
   always @(posedge clock) begin
      answer_type w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (answers_due.size() == 0) begin
            $display("%0t unexpected response: exp none act %h/%0d",
                     $time, rsp_ch.found_value, rsp_ch.status);
            fault_count++;
         end else begin
            w = answers_due.pop_front();
            if (rsp_ch.found_value !== w.found_value) begin
               $display("%0t found_value mismatch: exp %h act %h",
                        $time, w.found_value, rsp_ch.found_value);
               fault_count++;
            end
            if (rsp_ch.status !== w.status) begin
               $display("%0t status mismatch: exp %0d act %0d",
                        $time, w.status, rsp_ch.status);
               fault_count++;
            end
         end
      end
   end

   initial begin
      stim_row_type plan [$];
      stim_row_type it;
      fault_count    = 0;
      shadow_entries = 0;
      shadow_total   = '0;
      send_idle_pct  = 24;
      recv_idle_pct  = 70;
      recv_hold      = 1'b0;
      stimulus_done  = 1'b0;
      req_ch.valid      = 1'b0;
      req_ch.mode       = MODE_ADD;
      req_ch.item_value = '0;
      req_ch.item_count = '0;
      req_ch.position   = '0;

      // Directed: empty table, extremes, zero count, saturation, ranks.
      plan.insert(plan.size(), typed_row(query_row(1), '0, ST_RANGE));
      plan.insert(plan.size(), typed_row(query_row('0), '0, ST_RANGE));
      plan.insert(plan.size(), typed_row(add_row(32'h8000_0000, 1), '0, ST_OK));
      plan.insert(plan.size(), typed_row(query_row(1), 32'h8000_0000, ST_OK));
      plan.insert(plan.size(), typed_row(add_row(32'h7FFF_FFFF, 32'hFFFF_FFFF), '0, ST_OK));
      plan.insert(plan.size(), add_row(32'h7FFF_FFFF, 32'hFFFF_FFFF));   // count saturates
      plan.insert(plan.size(), add_row(32'd0, 32'd0));                   // holds no rank
      plan.insert(plan.size(), add_row(32'hFFFF_FFFF, 32'd3));
      plan.insert(plan.size(), add_row(32'd5, 32'd2));
      plan.insert(plan.size(), add_row(32'd5, 32'd1));
      plan.insert(plan.size(), query_row(2));
      plan.insert(plan.size(), query_row(4));
      plan.insert(plan.size(), query_row(5));
      plan.insert(plan.size(), query_row(7));
      plan.insert(plan.size(), query_row(42'h1_0000_0006));
      plan.insert(plan.size(), query_row(42'h1_0000_0007));
      plan.insert(plan.size(), typed_row(query_row(RANK_MAX), '0, ST_RANGE));
      plan.insert(plan.size(), query_row(42'h2AA_AAAA_AAAA));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[n])
         offer_item(plan[n]);

      // Random phases: receiver slow, then sender slow, then both flat out.
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 70 : 0;
         recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 24 : 0;
         for (int n = 0; n < 180; n++) begin
            it = ($urandom_range(1)) ? add_row(pick_value(), pick_count())
                                     : query_row(pick_rank());
            offer_item(it);
         end
      end

      // A new value below the top entry, another add to the bottom value, then a last round of ranks.
      offer_item(add_row(32'h2000_0001, 1));
      offer_item(add_row(32'h8000_0000, 1));
      for (int n = 0; n < 20; n++)
         offer_item(query_row(pick_rank()));
      req_ch.valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // Long hold-off on the response side while requests keep coming.
   initial begin
      int unsigned held;
      wait (!reset);
      repeat (400) @(negedge clock);
      recv_hold = 1'b1;
      held = 0;
      while (held < 3000) begin
         @(negedge clock);
         held++;
      end
      recv_hold = 1'b0;
   end

   initial begin
      wait (stimulus_done);
      while (answers_due.size() != 0)
         @(posedge clock);
      repeat (2200) @(posedge clock);
      if (fault_count == 0 && answers_due.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #200ms;
      $display("status: fail");
      $finish;
   end

endmodule
